// ----- rtl/core/sat_pkg.sv -----
// Package: types and codes shared by the subscriber aging table modules
`default_nettype none
package sat_pkg;

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_SWEEP    = 2'd1,
    CMD_LOOKUP   = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_NOTICE = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_LOOKUP = 2'd3
  } kind_t;

  localparam logic REG_SEND   = 1'b0;
  localparam logic REG_EXPIRE = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] subscriber_type;
    logic [31:0] subscriber_id;
    logic [31:0] now_seconds;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] out_type;
    logic [31:0] out_id;
    logic        found;
    logic        table_full;
    logic [5:0]  entry_count;
    logic [31:0] request_stamp;
    logic [31:0] update_stamp;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] req;
    logic [31:0] upd;
  } ent_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_EV,
    ST_DECIDE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_SWA_RD,
    ST_SWA_EXP,
    ST_SWA_SEND,
    ST_SWB,
    ST_SWB_EV,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/sat_mem.sv -----
// Entry memory: one write port, one registered read port
`default_nettype none
module sat_mem
  import sat_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire ent_t          wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output ent_t               rdata
);

  ent_t mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/sat_cmp.sv -----
// Shared aging unit: 33-bit stamp plus interval, compared against now
`default_nettype none
module sat_cmp (
  input  wire logic [31:0] stamp,
  input  wire logic [31:0] interval,
  input  wire logic [31:0] now,
  output logic             older
);

  logic [32:0] sum;

  assign sum   = {1'b0, stamp} + {1'b0, interval};
  assign older = sum < {1'b0, now};

endmodule
`default_nettype wire

// ----- rtl/core/subscriber_aging_table_core.sv -----
// Top level: sorted subscriber table with register, sweep and lookup sequencer
// Register/lookup: linear search of the sorted table, then on insert a shift of the entries above the position.
// Sweep: compaction pass drops expired entries, then a backward pass emits a notice per flagged entry.
// One transaction at a time; in_ready only while idle.
// Synchronous active-low reset empties the table and clears both intervals.
`default_nettype none
module subscriber_aging_table_core
  import sat_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [31:0] cfg_wdata
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  state_t st_r, st_nxt, ret_r, ret_nxt;
  cmd_t   cmd_r, cmd_nxt;
  logic [63:0] key_r, key_nxt;
  logic [31:0] now_r, now_nxt;
  logic [CW-1:0] idx_r, idx_nxt, wp_r, wp_nxt, pos_r, pos_nxt, cnt_r, cnt_nxt;
  logic hit_r, hit_nxt;
  logic [TABLE_DEPTH-1:0] flag_r, flag_nxt;
  out_t out_r, out_nxt;
  logic [31:0] send_r, exp_r;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  ent_t          wdata, rdata;
  logic [31:0]   cmp_stamp, cmp_int;
  logic          older;
  logic [CW-1:0] idx_dec;
  logic          idx_at_cnt, key_lt;

  sat_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  assign cmp_stamp = (st_r == ST_SWA_EXP) ? rdata.req : rdata.upd;
  assign cmp_int   = (st_r == ST_SWA_EXP) ? exp_r : send_r;

  sat_cmp u_cmp (.stamp(cmp_stamp), .interval(cmp_int), .now(now_r), .older(older));

  assign idx_dec    = idx_r - CW'(1);
  assign idx_at_cnt = idx_r == cnt_r;
  assign key_lt     = rdata.key < key_r;

  assign in_ready  = st_r == ST_IDLE;
  assign out_valid = st_r == ST_OUT;
  assign out_data  = out_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (cmd_t'(in_data.command))
            CMD_REGISTER, CMD_LOOKUP: st_nxt = ST_FIND_RD;
            CMD_SWEEP:                st_nxt = ST_SWA_RD;
            default:                  st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FIND_RD:  st_nxt = idx_at_cnt ? ST_DECIDE : ST_FIND_EV;
      ST_FIND_EV:  st_nxt = key_lt ? ST_FIND_RD : ST_DECIDE;
      ST_DECIDE: begin
        if (cmd_r == CMD_REGISTER && !hit_r && cnt_r != FULL) begin
          st_nxt = ST_SHIFT_RD;
        end else begin
          st_nxt = ST_OUT;
        end
      end
      ST_SHIFT_RD: st_nxt = (idx_r == pos_r) ? ST_OUT : ST_SHIFT_WR;
      ST_SHIFT_WR: st_nxt = ST_SHIFT_RD;
      ST_SWA_RD:   st_nxt = idx_at_cnt ? ST_SWB : ST_SWA_EXP;
      ST_SWA_EXP:  st_nxt = older ? ST_SWA_RD : ST_SWA_SEND;
      ST_SWA_SEND: st_nxt = ST_SWA_RD;
      ST_SWB: begin
        if (idx_r == '0) begin
          st_nxt = ST_OUT;
        end else if (flag_r[idx_dec[AW-1:0]]) begin
          st_nxt = ST_SWB_EV;
        end
      end
      ST_SWB_EV:   st_nxt = ST_OUT;
      ST_OUT:      st_nxt = out_ready ? ret_r : ST_OUT;
      default:     st_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    ret_nxt  = ret_r;
    cmd_nxt  = cmd_r;
    key_nxt  = key_r;
    now_nxt  = now_r;
    idx_nxt  = idx_r;
    wp_nxt   = wp_r;
    pos_nxt  = pos_r;
    cnt_nxt  = cnt_r;
    hit_nxt  = hit_r;
    flag_nxt = flag_r;
    out_nxt  = out_r;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = pos_r[AW-1:0];
    raddr    = idx_r[AW-1:0];
    wdata    = rdata;
    unique case (st_r)
      ST_IDLE: begin
        cmd_nxt = cmd_t'(in_data.command);
        key_nxt = {in_data.subscriber_type, in_data.subscriber_id};
        now_nxt = in_data.now_seconds;
        idx_nxt = '0;
        wp_nxt  = '0;
        ret_nxt = ST_IDLE;
      end
      ST_FIND_RD: begin
        if (idx_at_cnt) begin
          pos_nxt = idx_r;
          hit_nxt = 1'b0;
        end else begin
          re = 1'b1;
        end
      end
      ST_FIND_EV: begin
        if (key_lt) begin
          idx_nxt = idx_r + CW'(1);
        end else begin
          pos_nxt = idx_r;
          hit_nxt = rdata.key == key_r;
        end
      end
      ST_DECIDE: begin
        out_nxt = '{result_kind: KIND_ACK, out_type: key_r[63:32], out_id: key_r[31:0],
                    found: hit_r, table_full: 1'b0, entry_count: 6'(cnt_r),
                    request_stamp: '0, update_stamp: '0, last_of_run: 1'b1};
        ret_nxt = ST_IDLE;
        if (cmd_r == CMD_LOOKUP) begin
          out_nxt.result_kind = KIND_LOOKUP;
          if (hit_r) begin
            out_nxt.request_stamp = rdata.req;
            out_nxt.update_stamp  = rdata.upd;
          end
        end else if (hit_r) begin
          we      = 1'b1;
          wdata   = '{key: key_r, req: now_r, upd: rdata.upd};
          out_nxt.request_stamp = now_r;
          out_nxt.update_stamp  = rdata.upd;
        end else if (cnt_r == FULL) begin
          out_nxt.table_full = 1'b1;
        end else begin
          idx_nxt = cnt_r;
        end
      end
      ST_SHIFT_RD: begin
        if (idx_r == pos_r) begin
          we      = 1'b1;
          wdata   = '{key: key_r, req: now_r, upd: '0};
          cnt_nxt = cnt_r + CW'(1);
          out_nxt.entry_count   = 6'(cnt_r + CW'(1));
          out_nxt.request_stamp = now_r;
        end else begin
          re    = 1'b1;
          raddr = idx_dec[AW-1:0];
        end
      end
      ST_SHIFT_WR: begin
        we      = 1'b1;
        waddr   = idx_r[AW-1:0];
        idx_nxt = idx_dec;
      end
      ST_SWA_RD: begin
        if (idx_at_cnt) begin
          cnt_nxt = wp_r;
          idx_nxt = wp_r;
        end else begin
          re = 1'b1;
        end
      end
      ST_SWA_EXP: begin
        if (older) begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      ST_SWA_SEND: begin
        we    = 1'b1;
        waddr = wp_r[AW-1:0];
        wdata = '{key: rdata.key, req: rdata.req, upd: older ? now_r : rdata.upd};
        flag_nxt[wp_r[AW-1:0]] = older;
        wp_nxt  = wp_r + CW'(1);
        idx_nxt = idx_r + CW'(1);
      end
      ST_SWB: begin
        if (idx_r == '0) begin
          out_nxt = '{result_kind: KIND_DONE, out_type: '0, out_id: '0, found: 1'b0,
                      table_full: 1'b0, entry_count: 6'(cnt_r), request_stamp: '0,
                      update_stamp: '0, last_of_run: 1'b1};
          ret_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_dec;
          if (flag_r[idx_dec[AW-1:0]]) begin
            re    = 1'b1;
            raddr = idx_dec[AW-1:0];
          end
        end
      end
      ST_SWB_EV: begin
        out_nxt = '{result_kind: KIND_NOTICE, out_type: rdata.key[63:32],
                    out_id: rdata.key[31:0], found: 1'b1, table_full: 1'b0,
                    entry_count: 6'(cnt_r), request_stamp: rdata.req,
                    update_stamp: rdata.upd, last_of_run: 1'b0};
        ret_nxt = ST_SWB;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      ret_r  <= ST_IDLE;
      cnt_r  <= '0;
      send_r <= '0;
      exp_r  <= '0;
    end else begin
      st_r  <= st_nxt;
      ret_r <= ret_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        if (cfg_idx == REG_SEND) begin
          send_r <= cfg_wdata;
        end else begin
          exp_r <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    key_r  <= key_nxt;
    now_r  <= now_nxt;
    idx_r  <= idx_nxt;
    wp_r   <= wp_nxt;
    pos_r  <= pos_nxt;
    hit_r  <= hit_nxt;
    flag_r <= flag_nxt;
    out_r  <= out_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL) else $error("live count beyond table depth");

  a_compact: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SWA_EXP || st_r == ST_SWA_SEND) |-> wp_r <= idx_r)
    else $error("compaction write pointer ahead of read pointer");

  a_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SHIFT_WR) |-> idx_r > pos_r)
    else $error("insert shift below insert position");

  a_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SHIFT_RD && idx_r == pos_r) |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("insert did not grow the table");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for the subscriber aging table: predicts results of register, sweep and lookup
`timescale 1ns / 100ps
module tb_top;
  import sat_pkg::*;

  localparam int DEPTH = 32;

  class table_scoreboard;
    logic [63:0] keys[DEPTH];
    logic [31:0] req_t[DEPTH];
    logic [31:0] upd_t[DEPTH];
    int unsigned live;
    logic [31:0] send_iv;
    logic [31:0] expire_iv;
    out_t pending[$];
    int errors;

    function new();
      live = 0;
      send_iv = 0;
      expire_iv = 0;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] v);
      if (idx == REG_SEND) send_iv = v;
      else expire_iv = v;
    endfunction

    function out_t mk(kind_t k, logic [63:0] key, logic f, logic full, logic [31:0] rq,
                      logic [31:0] up);
      out_t o;
      o = '0;
      o.result_kind = k;
      o.out_type = key[63:32];
      o.out_id = key[31:0];
      o.found = f;
      o.table_full = full;
      o.request_stamp = rq;
      o.update_stamp = up;
      return o;
    endfunction

    function void note_input(in_t t);
      out_t res[$];
      logic [63:0] key;
      int unsigned p;
      bit hit;
      key = {t.subscriber_type, t.subscriber_id};
      if (t.command == CMD_REGISTER || t.command == CMD_LOOKUP) begin
        p = 0;
        while (p < live && keys[p] < key) p++;
        hit = (p < live) && (keys[p] == key);
        if (t.command == CMD_LOOKUP) begin
          if (hit) res.push_back(mk(KIND_LOOKUP, key, 1'b1, 1'b0, req_t[p], upd_t[p]));
          else res.push_back(mk(KIND_LOOKUP, key, 1'b0, 1'b0, '0, '0));
        end else if (hit) begin
          req_t[p] = t.now_seconds;
          res.push_back(mk(KIND_ACK, key, 1'b1, 1'b0, t.now_seconds, upd_t[p]));
        end else if (live >= DEPTH) begin
          res.push_back(mk(KIND_ACK, key, 1'b0, 1'b1, '0, '0));
        end else begin
          for (int j = live; j > p; j--) begin
            keys[j] = keys[j-1];
            req_t[j] = req_t[j-1];
            upd_t[j] = upd_t[j-1];
          end
          keys[p] = key;
          req_t[p] = t.now_seconds;
          upd_t[p] = '0;
          live++;
          res.push_back(mk(KIND_ACK, key, 1'b0, 1'b0, t.now_seconds, '0));
        end
      end else if (t.command == CMD_SWEEP) begin
        for (int i = live - 1; i >= 0; i--) begin
          if ({1'b0, req_t[i]} + {1'b0, expire_iv} < {1'b0, t.now_seconds}) begin
            for (int j = i; j + 1 < live; j++) begin
              keys[j] = keys[j+1];
              req_t[j] = req_t[j+1];
              upd_t[j] = upd_t[j+1];
            end
            live--;
          end else if ({1'b0, upd_t[i]} + {1'b0, send_iv} < {1'b0, t.now_seconds}) begin
            upd_t[i] = t.now_seconds;
            res.push_back(mk(KIND_NOTICE, keys[i], 1'b1, 1'b0, req_t[i], t.now_seconds));
          end
        end
        res.push_back(mk(KIND_DONE, '0, 1'b0, 1'b0, '0, '0));
      end
      foreach (res[k]) begin
        res[k].entry_count = live[5:0];
        res[k].last_of_run = (k == res.size() - 1);
        pending.push_back(res[k]);
      end
    endfunction

    function void check_result(out_t a);
      out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result kind %0d", a.result_kind);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a !== e) errors++;
      if (a.result_kind !== e.result_kind)
        $error("result_kind exp %0d got %0d", e.result_kind, a.result_kind);
      if (a.out_type !== e.out_type) $error("out_type exp %h got %h", e.out_type, a.out_type);
      if (a.out_id !== e.out_id) $error("out_id exp %h got %h", e.out_id, a.out_id);
      if (a.found !== e.found) $error("found exp %0d got %0d", e.found, a.found);
      if (a.table_full !== e.table_full)
        $error("table_full exp %0d got %0d", e.table_full, a.table_full);
      if (a.entry_count !== e.entry_count)
        $error("entry_count exp %0d got %0d", e.entry_count, a.entry_count);
      if (a.request_stamp !== e.request_stamp)
        $error("request_stamp exp %h got %h", e.request_stamp, a.request_stamp);
      if (a.update_stamp !== e.update_stamp)
        $error("update_stamp exp %h got %h", e.update_stamp, a.update_stamp);
      if (a.last_of_run !== e.last_of_run)
        $error("last_of_run exp %0d got %0d", e.last_of_run, a.last_of_run);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_we;
  logic cfg_idx;
  logic [31:0] cfg_wdata;

  table_scoreboard sb;
  bit calm;
  logic [31:0] clock_s;
  logic [31:0] known_type[8];
  logic [31:0] known_id[8];

  subscriber_aging_table_core #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // receiver stalls in bursts
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 6);
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // valid is left high after acceptance; a pause in the next call or wait_empty drops it
  task automatic send_item(cmd_t c, logic [31:0] ty, logic [31:0] id, logic [31:0] now);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_data <= '{command: c, subscriber_type: ty, subscriber_id: id, now_seconds: now};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(in_data);
    @(negedge clk);
  endtask

  task automatic wait_empty();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending.size() != 0);
  endtask

  task automatic drain();
    wait_empty();
    repeat (150) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_item();
    cmd_t c;
    logic [31:0] ty;
    logic [31:0] id;
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 50) c = CMD_REGISTER;
    else if (r < 70) c = CMD_SWEEP;
    else if (r < 95) c = CMD_LOOKUP;
    else c = CMD_UNUSED;
    k = $urandom_range(0, 7);
    if ($urandom_range(0, 2) == 0) begin
      ty = $urandom();
      id = $urandom();
    end else begin
      ty = known_type[k];
      id = known_id[k] + $urandom_range(0, 4);
    end
    clock_s = clock_s + $urandom_range(0, 40);
    send_item(c, ty, id, clock_s);
  endtask

  initial begin
    sb = new();
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = REG_SEND;
    cfg_wdata = '0;
    clock_s = 32'd100;
    foreach (known_type[i]) begin
      known_type[i] = (i < 2) ? 32'(i) * 32'hFFFF_FFFF : $urandom_range(0, 3);
      known_id[i] = (i == 0) ? 32'hFFFF_FFF0 : $urandom();
    end
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, empty sweep, lookups, fill to full
    write_reg(REG_SEND, 32'hFFFF_FFFF);
    write_reg(REG_EXPIRE, 32'hFFFF_FFFF);
    send_item(CMD_SWEEP, '0, '0, 32'hFFFF_FFFF);
    send_item(CMD_LOOKUP, '0, '0, '0);
    send_item(CMD_REGISTER, '0, '0, '0);
    send_item(CMD_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_REGISTER, '0, '0, 32'd5);
    send_item(CMD_LOOKUP, '0, '0, '0);
    send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send_item(CMD_LOOKUP, 32'h1, '0, '0);
    send_item(CMD_UNUSED, 32'h5555_AAAA, 32'hAAAA_5555, 32'h1234_5678);
    send_item(CMD_SWEEP, '0, '0, 32'hFFFF_FFFF);
    for (int i = 0; i < 31; i++)
      send_item(CMD_REGISTER, 32'h8000_0000 >> (i % 4), 32'(i) * 32'h0101_0101, 32'd50);
    send_item(CMD_REGISTER, 32'h7, 32'h7, 32'd60);
    drain();
    write_reg(REG_SEND, '0);
    write_reg(REG_EXPIRE, 32'd20);
    send_item(CMD_SWEEP, '0, '0, 32'd60);
    send_item(CMD_SWEEP, '0, '0, 32'd80);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(REG_SEND, 32'd10); write_reg(REG_EXPIRE, 32'd200); end
        1: begin write_reg(REG_SEND, 32'd0); write_reg(REG_EXPIRE, 32'd60); end
        2: begin write_reg(REG_SEND, 32'd40); write_reg(REG_EXPIRE, 32'hFFFF_FFFF); end
        3: begin write_reg(REG_SEND, 32'hFFFF_FFF0); write_reg(REG_EXPIRE, 32'd0); end
        default: begin write_reg(REG_SEND, 32'd25); write_reg(REG_EXPIRE, 32'd120); end
      endcase
      if (ph == 4) calm = 1'b1;
      for (int i = 0; i < 40; i++) begin
        random_item();
        if (ph == 1 && i == 20) wait_empty();
      end
      drain();
    end
    if (sb.errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule
